// File: rtl/rtp_pkg.sv
// Shared constants, data types and the arctangent table of the rectangular-to-polar
// converter. Depends on nothing; every other module imports it.
`default_nettype none

package rtp_pkg;

	// coordinate width and number of rotation cells
	localparam int CW         = 16;
	localparam int ITERATIONS = 16;

	// guard bits below the coordinate point in the rotation datapath
	localparam int GUARD   = 16;
	localparam int DP_W    = CW + GUARD + 2;
	localparam int Z_W     = 34;
	localparam int SHIFT_W = $clog2(ITERATIONS);

	// square-root datapath widths
	localparam int SUM_W = 2 * CW;
	localparam int REM_W = CW + 3;

	// output widths and limits
	localparam int MAG_W     = 16;
	localparam int PH_W      = 16;
	localparam int PHASE_MAX = 25736;
	localparam int MAG_CMP_W = (CW + 1 > MAG_W + 1) ? CW + 1 : MAG_W + 1;

	// pi/2 in Q2.30
	localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(1686629713);

	// chain length shared by both rows of cells, and request-to-result latency
	localparam int LEN     = (ITERATIONS > CW + 1) ? ITERATIONS : CW + 1;
	localparam int LATENCY = LEN + 3;

	// one rotation cell's worth of data
	typedef struct packed {
		logic                   vld;
		logic                   org;
		logic signed [DP_W-1:0] x;
		logic signed [DP_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	// one square-root cell's worth of data
	typedef struct packed {
		logic [SUM_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [CW-1:0]    root;
	} sqrt_t;

	// atan(2^-i) in radians, Q2.30
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rect_to_polar_converter.sv
// Path: a request passes the input register, the pre-rotation register, LEN cells and the output
// register, LEN being the longer of the rotation chain and the root chain plus one.
// Throughput: one request per cycle; busy stays low, as every cell hands its data on
// in every cycle, and results leave unconditionally.
// Reset: arst_n clears all request markers and the done strobe; data registers are not reset.
`default_nettype none

module rect_to_polar_converter import rtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [15:0]      x_coord,
	input  logic signed [15:0]      y_coord,
	output logic                    done,
	output logic        [MAG_W-1:0] magnitude,
	output logic signed [PH_W-1:0]  phase
);

	logic                     valid_s1;
	logic signed [CW-1:0]     x_s1;
	logic signed [CW-1:0]     y_s1;
	logic signed [CW:0]       px;
	logic signed [CW:0]       py;
	logic signed [Z_W-1:0]    pz;
	cordic_t                  init_n;
	cordic_t                  init_s2;
	logic                     valid_s2;
	logic        [SUM_W-1:0]  sqx_s2;
	logic        [SUM_W-1:0]  sqy_s2;
	logic        [SUM_W-1:0]  sum_s3;
	cordic_t                  cord_c [LEN+1];
	sqrt_t                    sq_c   [LEN];

	assign busy = 1'b0;

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= CW'($unsigned(x_coord));
		y_s1 <= CW'($unsigned(y_coord));
	end

	// pre-rotate by a quarter turn into the right half plane
	always_comb begin
		if (x_s1[CW-1]) begin
			if (!y_s1[CW-1]) begin
				px = (CW+1)'(y_s1);
				py = -(CW+1)'(x_s1);
				pz = HALF_PI;
			end else begin
				px = -(CW+1)'(y_s1);
				py = (CW+1)'(x_s1);
				pz = -HALF_PI;
			end
		end else begin
			px = (CW+1)'(x_s1);
			py = (CW+1)'(y_s1);
			pz = '0;
		end
		init_n.vld = valid_s1;
		init_n.org = (x_s1 == '0) && (y_s1 == '0);
		init_n.x   = {{(DP_W-CW-1-GUARD){px[CW]}}, px, {GUARD{1'b0}}};
		init_n.y   = {{(DP_W-CW-1-GUARD){py[CW]}}, py, {GUARD{1'b0}}};
		init_n.z   = pz;
	end

	// register the pre-rotated vector and the squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		init_s2 <= init_n;
		sqx_s2  <= $unsigned(SUM_W'(x_s1) * SUM_W'(x_s1));
		sqy_s2  <= $unsigned(SUM_W'(y_s1) * SUM_W'(y_s1));
	end

	always_comb begin
		cord_c[0]     = init_s2;
		cord_c[0].vld = valid_s2;
	end

	// sum of squares feeds the root chain one stage behind
	always_ff @(posedge clk) begin
		sum_s3 <= sqx_s2 + sqy_s2;
	end

	always_comb begin
		sq_c[0].rad  = sum_s3;
		sq_c[0].rem  = '0;
		sq_c[0].root = '0;
	end

	// row of rotation cells, padded to the common length
	for (genvar k = 0; k < LEN; k++) begin : g_cord
		if (k < ITERATIONS) begin : g_cell
			rtp_cordic_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (SHIFT_W'(k)),
				.cin    (cord_c[k]),
				.cout   (cord_c[k+1])
			);
		end else begin : g_pad
			cordic_t pad_q;
			logic    pad_vld_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pad_vld_q <= 1'b0;
				end else begin
					pad_vld_q <= cord_c[k].vld;
				end
			end
			always_ff @(posedge clk) begin
				pad_q <= cord_c[k];
			end
			always_comb begin
				cord_c[k+1]     = pad_q;
				cord_c[k+1].vld = pad_vld_q;
			end
		end
	end

	// row of root digit cells, padded to the common length
	for (genvar j = 0; j < LEN - 1; j++) begin : g_sqrt
		if (j < CW) begin : g_cell
			rtp_sqrt_cell u_cell (
				.clk  (clk),
				.sin  (sq_c[j]),
				.sout (sq_c[j+1])
			);
		end else begin : g_pad
			sqrt_t pad_q;
			always_ff @(posedge clk) begin
				pad_q <= sq_c[j];
			end
			assign sq_c[j+1] = pad_q;
		end
	end

	rtp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.cin       (cord_c[LEN]),
		.sin       (sq_c[LEN-1]),
		.done      (done),
		.magnitude (magnitude),
		.phase     (phase)
	);

`ifndef SYNTHESIS
	// every result strobe traces back to a request a fixed latency earlier
	a_done_traces_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	// a request at the origin gives zero magnitude and zero phase
	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && x_coord == 16'sd0 && y_coord == 16'sd0)
		|-> ##LATENCY (done && magnitude == '0 && phase == '0))
		else $error("origin request did not give a zero result");

	// the phase of any result stays within plus/minus pi
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (phase <= PH_W'(PHASE_MAX) && phase >= -PH_W'(PHASE_MAX)))
		else $error("phase outside plus/minus pi");

	// the request marker enters the rotation row exactly as accepted
	a_chain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 cord_c[0].vld)
		else $error("accepted request lost before the rotation row");
`endif

endmodule

`default_nettype wire

// File: rtl/rtp_cordic_cell.sv
// One vectoring micro-rotation cell of the phase chain.
// Depends on rtp_pkg for widths, the cordic_t type and the arctangent table.
`default_nettype none

module rtp_cordic_cell import rtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SHIFT_W-1:0] shift,
	input  cordic_t            cin,
	output cordic_t            cout
);

	logic signed [DP_W-1:0] xs;
	logic signed [DP_W-1:0] ys;
	logic signed [Z_W-1:0]  da;
	cordic_t                nxt;
	cordic_t                dat_q;
	logic                   vld_q;

	// rotate toward the x axis, accumulate the angle
	always_comb begin
		xs  = cin.x >>> shift;
		ys  = cin.y >>> shift;
		da  = $signed({{(Z_W-32){1'b0}}, atan_q30(5'(shift))});
		nxt = cin;
		if (!cin.y[DP_W-1]) begin
			nxt.x = cin.x + ys;
			nxt.y = cin.y - xs;
			nxt.z = cin.z + da;
		end else begin
			nxt.x = cin.x - ys;
			nxt.y = cin.y + xs;
			nxt.z = cin.z - da;
		end
	end

	// advance the request marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= cin.vld;
		end
	end

	// advance the data
	always_ff @(posedge clk) begin
		dat_q <= nxt;
	end

	always_comb begin
		cout     = dat_q;
		cout.vld = vld_q;
	end

endmodule

`default_nettype wire

// File: rtl/rtp_sqrt_cell.sv
// One digit cell of the square-root chain: brings in two radicand bits, decides one root bit.
// Depends on rtp_pkg for widths and the sqrt_t type.
`default_nettype none

module rtp_sqrt_cell import rtp_pkg::*; (
	input  logic  clk,
	input  sqrt_t sin,
	output sqrt_t sout
);

	logic [REM_W-1:0] rn;
	logic [REM_W-1:0] trial;
	logic             ge;
	sqrt_t            nxt;

	// trial subtract of (4*root + 1) from the shifted remainder
	always_comb begin
		rn       = {sin.rem[REM_W-3:0], sin.rad[SUM_W-1 -: 2]};
		trial    = {1'b0, sin.root, 2'b01};
		ge       = (rn >= trial);
		nxt.rad  = {sin.rad[SUM_W-3:0], 2'b00};
		nxt.rem  = ge ? (rn - trial) : rn;
		nxt.root = {sin.root[CW-2:0], ge};
	end

	// hand the partial result to the next cell
	always_ff @(posedge clk) begin
		sout <= nxt;
	end

endmodule

`default_nettype wire

// File: rtl/rtp_finish.sv
// Output stage: rounds the root and the angle, clamps both and registers the result.
// Depends on rtp_pkg for widths, limits and the chain data types.
`default_nettype none

module rtp_finish import rtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cordic_t                 cin,
	input  sqrt_t                   sin,
	output logic                    done,
	output logic        [MAG_W-1:0] magnitude,
	output logic signed [PH_W-1:0]  phase
);

	logic        [CW:0]          mag_r;
	logic        [MAG_CMP_W-1:0] mag_x;
	logic        [MAG_W-1:0]     mag_n;
	logic signed [Z_W-1:0]       zsum;
	logic signed [Z_W-1:0]       zr;
	logic signed [PH_W-1:0]      ph_n;
	logic                        done_q;
	logic        [MAG_W-1:0]     magnitude_q;
	logic signed [PH_W-1:0]      phase_q;

	// round the root up when the remainder exceeds it, then saturate
	always_comb begin
		mag_r = {1'b0, sin.root} + (CW+1)'(sin.rem > REM_W'(sin.root));
		mag_x = MAG_CMP_W'(mag_r);
		if (mag_x > MAG_CMP_W'({MAG_W{1'b1}})) begin
			mag_n = {MAG_W{1'b1}};
		end else begin
			mag_n = mag_x[MAG_W-1:0];
		end
	end

	// round Q2.30 to Q3.13, clamp to plus/minus pi, zero at the origin
	always_comb begin
		zsum = cin.z + Z_W'(65536);
		zr   = zsum >>> 17;
		if (zr > Z_W'(PHASE_MAX)) begin
			zr = Z_W'(PHASE_MAX);
		end else if (zr < -Z_W'(PHASE_MAX)) begin
			zr = -Z_W'(PHASE_MAX);
		end
		ph_n = cin.org ? '0 : zr[PH_W-1:0];
	end

	// strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cin.vld;
		end
	end

	// hold the result values
	always_ff @(posedge clk) begin
		magnitude_q <= mag_n;
		phase_q     <= ph_n;
	end

	assign done      = done_q;
	assign magnitude = magnitude_q;
	assign phase     = phase_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench of rect_to_polar_converter: a directed table and random requests.
// Results are checked against a bit-exact predictor of the rounded root and the CORDIC phase.
// Depends on rtp_pkg and the converter RTL.
`default_nettype none

module tb_top;
	import rtp_pkg::*;

	localparam int     HALF_CLK      = 10;
	localparam int     RESET_CYCLES  = 7;
	localparam int     DIRECTED_ROWS = 22;
	localparam int     RANDOM_REQS   = 1200;
	localparam int     STALL_LIMIT   = 1000;
	localparam int     MAX_SHOWN     = 10;
	localparam int     ROT_GUARD     = 16;
	localparam int     PHASE_LIMIT   = 25736;
	localparam longint HALF_PI_Q30   = 64'sd1686629713;

	typedef struct packed {
		logic        [MAG_W-1:0] mag;
		logic signed [PH_W-1:0]  ph;
	} polar_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               typed;
		polar_t             res;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [15:0]      x_coord;
	logic signed [15:0]      y_coord;
	logic                    done;
	logic        [MAG_W-1:0] magnitude;
	logic signed [PH_W-1:0]  phase;

	polar_t expected_polar[$];
	int     mismatches  = 0;
	int     idle_cycles = 0;

	rect_to_polar_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.done      (done),
		.magnitude (magnitude),
		.phase     (phase)
	);

	always #(HALF_CLK) clk = ~clk;

	// atan(2^-i) in radians, Q2.30
	function automatic longint atan_step(input int i);
		longint v;
		case (i)
			0:  v = 64'h3243F6A8;  1:  v = 64'h1DAC6705;  2:  v = 64'h0FADBAFC;
			3:  v = 64'h07F56EA6;  4:  v = 64'h03FEAB76;  5:  v = 64'h01FFD55B;
			6:  v = 64'h00FFFAAA;  7:  v = 64'h007FFF55;  8:  v = 64'h003FFFEA;
			9:  v = 64'h001FFFFD;  10: v = 64'h000FFFFF;  11: v = 64'h0007FFFF;
			12: v = 64'h0003FFFF;  13: v = 64'h0001FFFF;  14: v = 64'h0000FFFF;
			15: v = 64'h00007FFF;  16: v = 64'h00003FFF;  17: v = 64'h00001FFF;
			18: v = 64'h00000FFF;  19: v = 64'h000007FF;  20: v = 64'h000003FF;
			21: v = 64'h000001FF;  22: v = 64'h000000FF;  23: v = 64'h0000007F;
			24: v = 64'h0000003F;  25: v = 64'h0000001F;  26: v = 64'h0000000F;
			27: v = 64'h00000008;  28: v = 64'h00000004;  29: v = 64'h00000002;
			30: v = 64'h00000001;
			default: v = 64'h0;
		endcase
		return v;
	endfunction

	// polar form of one point: rounded root of x*x+y*y and vectoring CORDIC phase
	function automatic polar_t polar_of(input logic signed [15:0] xi, input logic signed [15:0] yi);
		longint          xs, ys, cx, cy, cz, nx;
		longint unsigned rem, root, bitv;
		int              i;
		polar_t          r;
		xs = xi;
		ys = yi;
		r  = '0;
		if (xs == 0 && ys == 0)
			return r;
		// digit-by-digit root, round half up
		rem  = xs * xs + ys * ys;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		if (rem > root)
			root++;
		if (root > 64'hFFFF)
			root = 64'hFFFF;
		r.mag = root[MAG_W-1:0];
		// pre-rotate a quarter turn into the right half plane
		cz = 0;
		if (xs < 0) begin
			if (ys >= 0) begin
				cx = ys;
				cy = -xs;
				cz = HALF_PI_Q30;
			end else begin
				cx = -ys;
				cy = xs;
				cz = -HALF_PI_Q30;
			end
		end else begin
			cx = xs;
			cy = ys;
		end
		cx = cx * (64'sd1 <<< ROT_GUARD);
		cy = cy * (64'sd1 <<< ROT_GUARD);
		// drive y toward zero, accumulate the angle
		for (i = 0; i < ITERATIONS && i < 32; i++) begin
			if (cy >= 0) begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				cz = cz + atan_step(i);
			end else begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				cz = cz - atan_step(i);
			end
			cx = nx;
		end
		// round Q2.30 to Q3.13 and clamp to +-pi
		cz = (cz + 64'sd65536) >>> 17;
		if (cz > PHASE_LIMIT)
			cz = PHASE_LIMIT;
		if (cz < -PHASE_LIMIT)
			cz = -PHASE_LIMIT;
		r.ph = cz[PH_W-1:0];
		return r;
	endfunction

	// directed table: axes, corners, unit points, origin with its result typed in
	function automatic dir_row_t dir_row(input int k);
		dir_row_t row;
		case (k)
			0:  row = {16'h0000, 16'h0000, 1'b1, 16'd0, 16'sd0};
			1:  row = {16'h7FFF, 16'h0000, 1'b0, 32'h0};
			2:  row = {16'h8000, 16'h0000, 1'b0, 32'h0};
			3:  row = {16'h0000, 16'h7FFF, 1'b0, 32'h0};
			4:  row = {16'h0000, 16'h8000, 1'b0, 32'h0};
			5:  row = {16'h7FFF, 16'h7FFF, 1'b0, 32'h0};
			6:  row = {16'h8000, 16'h8000, 1'b0, 32'h0};
			7:  row = {16'h8000, 16'h7FFF, 1'b0, 32'h0};
			8:  row = {16'h7FFF, 16'h8000, 1'b0, 32'h0};
			9:  row = {16'h0001, 16'h0000, 1'b0, 32'h0};
			10: row = {16'hFFFF, 16'h0000, 1'b0, 32'h0};
			11: row = {16'h0000, 16'h0001, 1'b0, 32'h0};
			12: row = {16'h0000, 16'hFFFF, 1'b0, 32'h0};
			13: row = {16'h0001, 16'h0001, 1'b0, 32'h0};
			14: row = {16'hFFFF, 16'hFFFF, 1'b0, 32'h0};
			15: row = {16'hFFFF, 16'h0001, 1'b0, 32'h0};
			16: row = {16'h0001, 16'hFFFF, 1'b0, 32'h0};
			17: row = {16'h8000, 16'h0001, 1'b0, 32'h0};
			18: row = {16'h8000, 16'hFFFF, 1'b0, 32'h0};
			19: row = {16'h0003, 16'h0004, 1'b0, 32'h0};
			20: row = {16'hFFFB, 16'hFFF4, 1'b0, 32'h0};
			default: row = {16'h5555, 16'hAAAA, 1'b0, 32'h0};
		endcase
		return row;
	endfunction

	function automatic logic signed [15:0] corner_value();
		logic signed [15:0] v;
		case ($urandom_range(0, 5))
			0: v = 16'h8000;
			1: v = 16'h8001;
			2: v = 16'hFFFF;
			3: v = 16'h0000;
			4: v = 16'h0001;
			default: v = 16'h7FFF;
		endcase
		return v;
	endfunction

	// draw one point: full-range points most often, with small, axis, corner and diagonal points mixed in
	task automatic pick_point(output logic signed [15:0] xv, output logic signed [15:0] yv);
		int                 sel;
		logic signed [15:0] a, b;
		sel = $urandom_range(0, 99);
		a   = 16'($urandom);
		b   = 16'(int'($urandom_range(0, 6)) - 3);
		if (sel < 40) begin
			xv = a;
			yv = 16'($urandom);
		end else if (sel < 60) begin
			xv = 16'(int'($urandom_range(0, 64)) - 32);
			yv = 16'(int'($urandom_range(0, 64)) - 32);
		end else if (sel < 72) begin
			if ($urandom_range(0, 1)) begin
				xv = a;
				yv = b;
			end else begin
				xv = b;
				yv = a;
			end
		end else if (sel < 84) begin
			xv = corner_value();
			yv = corner_value();
		end else begin
			xv = a;
			yv = $urandom_range(0, 1) ? a + b : -a + b;
		end
	endtask

	// present one request after an optional gap, wait for it to be taken, queue its expected result
	task automatic issue(input logic signed [15:0] xv, input logic signed [15:0] yv,
			input logic typed, input polar_t typed_res, input int gap);
		if (gap > 0) begin
			start   <= 1'b0;
			x_coord <= 16'($urandom);
			y_coord <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		x_coord <= xv;
		y_coord <= yv;
		do @(posedge clk); while (busy !== 1'b0);
		expected_polar.push_back(typed ? typed_res : polar_of(xv, yv));
	endtask

	// check each result strobe against the oldest expectation; watch for a stall
	always @(posedge clk) begin : check_results
		polar_t e;
		if (done === 1'b1) begin
			if (expected_polar.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: magnitude %0d phase %0d",
						magnitude, $signed(phase));
			end else begin
				e = expected_polar.pop_front();
				if (magnitude !== e.mag || phase !== e.ph) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: expected magnitude %0d phase %0d, got %0d %0d",
							e.mag, $signed(e.ph), magnitude, $signed(phase));
				end
			end
		end
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// reset, directed table, random requests, drain
	initial begin
		dir_row_t           row;
		logic signed [15:0] xv, yv;
		int                 k, n, gap, burst_left, sel;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		x_coord <= '0;
		y_coord <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIRECTED_ROWS; k++) begin
			row = dir_row(k);
			issue(row.x, row.y, row.typed, row.res, k % 4);
		end

		burst_left = 0;
		for (n = 0; n < RANDOM_REQS; n++) begin
			pick_point(xv, yv);
			// mostly back to back, some short gaps, a few long ones, and gapless bursts
			if (burst_left > 0) begin
				burst_left--;
				gap = 0;
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					burst_left = $urandom_range(30, 80);
				if (sel < 60)
					gap = 0;
				else if (sel < 88)
					gap = $urandom_range(1, 3);
				else if (sel < 97)
					gap = $urandom_range(4, 10);
				else
					gap = $urandom_range(20, 60);
			end
			issue(xv, yv, 1'b0, '0, gap);
		end
		start <= 1'b0;

		while (expected_polar.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
